// File: rtl/bin_packing_first_best_fit_macros.svh
// Assertion macros shared by the bin packer RTL.
`ifndef BIN_PACKING_FIRST_BEST_FIT_MACROS_SVH
`define BIN_PACKING_FIRST_BEST_FIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BPF_ASSERT_NOW(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("bin packer assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define BPF_ASSERT_NEXT(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("bin packer assertion failed");
`else
`define BPF_ASSERT_NOW(lbl, clk, rst, ant, cons)
`define BPF_ASSERT_NEXT(lbl, clk, rst, ant, cons)
`endif

`endif

// File: rtl/bpf_pkg.sv
// Package with the types and constants of the bin packer.
package bpf_pkg;

   localparam int MAX_BINS    = 256;
   localparam int BIN_IDX_W   = $clog2(MAX_BINS);
   localparam int BIN_CNT_W   = $clog2(MAX_BINS + 1);
   localparam int SIZE_W      = 16;
   localparam int RSP_IDX_W   = 8;
   localparam int RSP_CNT_W   = 9;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE     = 1'b1;

   localparam logic FIT_FIRST = 1'b0;
   localparam logic FIT_BEST  = 1'b1;

   localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic              FIT_MODE_RESET = FIT_BEST;

   typedef struct packed {
      logic [SIZE_W-1:0] item_size;
      logic              first_item;
   } req_type;

   typedef struct packed {
      logic [RSP_IDX_W-1:0] bin_index;
      logic [RSP_CNT_W-1:0] bins_used;
      logic                 overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

// File: rtl/bpf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bin_packing_first_best_fit.sv
// Top level of the online first-fit / best-fit bin packer.
// The block takes one item at a time: busy stays high after acceptance until the result is registered.
// The scan reads one stored bin load per cycle from one RAM port and compares each load as it returns.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset is synchronous and active high; it empties the store and restores the control and configuration registers.
module bin_packing_first_best_fit
   import bpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "bin_packing_first_best_fit_macros.svh"

   // Sequencer state.
   state_type state_ff, state_in;

   // Configuration registers.
   logic [SIZE_W-1:0] capacity_ff;
   logic              fit_mode_ff;

   // Item and scan context.
   logic [SIZE_W-1:0]    size_ff;
   logic [BIN_CNT_W-1:0] open_ff, open_in;
   logic [BIN_CNT_W-1:0] issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [BIN_IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic                 found_ff, found_in;
   logic [BIN_IDX_W-1:0] pick_ff, pick_in;
   logic [SIZE_W-1:0]    best_ff, best_in;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // RAM port signals.
   logic                 ram_wr_en, ram_rd_en;
   logic [BIN_IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [SIZE_W-1:0]    ram_wr_data, ram_rd_data;

   // Shared compare unit: does the load just read still take the item?
   logic               accept;
   logic [SIZE_W:0]    sum_wide;
   logic               fits;
   logic               ff_hit;
   logic               can_issue;
   logic               scan_done;

   assign accept    = start && !busy;
   assign sum_wide  = {1'b0, ram_rd_data} + {1'b0, size_ff};
   assign fits      = pend_ff && (sum_wide <= {1'b0, capacity_ff});
   assign ff_hit    = fits && (fit_mode_ff == FIT_FIRST);
   assign can_issue = (issue_ff < open_ff) && !ff_hit;
   // The scan ends on a first-fit hit, in the cycle that compares the last load, or at once with no open bin.
   assign scan_done = ff_hit || (issue_ff == open_ff);

   bpf_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (MAX_BINS)
   ) u_load_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output and datapath control of the sequencer.
   always_comb begin
      open_in      = open_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pick_ff;
      ram_wr_data  = best_ff + size_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[BIN_IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // A first item empties the store before it is placed.
               if (req_data.first_item) begin
                  open_in = '0;
               end
               issue_in = '0;
               found_in = 1'b0;
               pick_in  = '0;
               best_in  = '0;
            end
         end
         ST_SCAN: begin
            // Issue the next read while the previous load is compared.
            if (can_issue) begin
               ram_rd_en  = 1'b1;
               issue_in   = issue_ff + 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = issue_ff[BIN_IDX_W-1:0];
            end
            if (ff_hit) begin
               found_in = 1'b1;
               pick_in  = cmp_idx_ff;
               best_in  = ram_rd_data;
            end else if (fits && (ram_rd_data > best_ff)) begin
               // Best fit: strictly greater load wins, so the earliest bin keeps ties
               // and empty bins never take part.
               found_in = 1'b1;
               pick_in  = cmp_idx_ff;
               best_in  = ram_rd_data;
            end
         end
         ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               ram_wr_en          = 1'b1;
               rsp_in.bin_index   = RSP_IDX_W'(pick_ff);
               rsp_in.bins_used   = RSP_CNT_W'(open_ff);
               rsp_in.overflow    = 1'b0;
            end else if (open_ff < BIN_CNT_W'(MAX_BINS)) begin
               // No open bin takes the item: open a new one, even for an oversize item.
               ram_wr_en          = 1'b1;
               ram_wr_addr        = open_ff[BIN_IDX_W-1:0];
               ram_wr_data        = size_ff;
               open_in            = open_ff + 1'b1;
               rsp_in.bin_index   = RSP_IDX_W'(open_ff);
               rsp_in.bins_used   = RSP_CNT_W'(open_ff + 1'b1);
               rsp_in.overflow    = 1'b0;
            end else begin
               // Store full: the item is dropped.
               rsp_in.bin_index   = '0;
               rsp_in.bins_used   = RSP_CNT_W'(open_ff);
               rsp_in.overflow    = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAPACITY_RESET;
         fit_mode_ff  <= FIT_MODE_RESET;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BIN_CAPACITY: capacity_ff <= csr_wdata[SIZE_W-1:0];
               CSR_FIT_MODE:     fit_mode_ff <= csr_wdata[0];
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         size_ff <= req_data.item_size;
      end
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted item keeps the block busy in the following cycle.
   `BPF_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   // A dropped item is reported only when every bin is open.
   `BPF_ASSERT_NOW(a_overflow_full, clock, reset, rsp_valid && rsp_data.overflow,
      rsp_data.bins_used == RSP_CNT_W'(MAX_BINS))
   // A placed item lands in a bin that is open.
   `BPF_ASSERT_NOW(a_index_open, clock, reset, rsp_valid && !rsp_data.overflow,
      RSP_CNT_W'(rsp_data.bin_index) < rsp_data.bins_used)
   // The open-bin count never passes the store depth.
   `BPF_ASSERT_NOW(a_open_range, clock, reset, 1'b1, open_ff <= BIN_CNT_W'(MAX_BINS))

endmodule
